[rtl/hafp_pkg.sv]
// Shared constants, pipeline record type and micro-rotation angle table
// for the heading angle pipeline. No dependencies.
package hafp_pkg;

  localparam int COORD_WIDTH_DEF     = 32;
  localparam int ANGLE_FRAC_BITS_DEF = 16;
  localparam int HEAD_W              = 25;
  localparam int XW                  = 64;
  localparam int NORM_TOP            = 59;
  localparam int SH_W                = 6;
  localparam int ZW                  = 44;
  localparam int Z_FRAC              = 32;
  localparam int CORDIC_ITERS        = 40;
  localparam int ATAN_SH_LIMIT       = 40;
  localparam int ATAN_TERMS          = 20;
  localparam logic [63:0] DEG_PER_RAD = 64'd246083499208;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } cord_t;

  function automatic logic [63:0] div_odd(input logic [63:0] v, input int k);
    logic [63:0] q;
    unique case (k)
      0:  q = v / 1;
      1:  q = v / 3;
      2:  q = v / 5;
      3:  q = v / 7;
      4:  q = v / 9;
      5:  q = v / 11;
      6:  q = v / 13;
      7:  q = v / 15;
      8:  q = v / 17;
      9:  q = v / 19;
      10: q = v / 21;
      11: q = v / 23;
      12: q = v / 25;
      13: q = v / 27;
      14: q = v / 29;
      15: q = v / 31;
      16: q = v / 33;
      17: q = v / 35;
      18: q = v / 37;
      19: q = v / 39;
      default: q = v;
    endcase
    return q;
  endfunction

  // atan(2^-i) in Q32 degrees, from the alternating arctangent series
  function automatic logic [ZW-1:0] atan_step(input int i);
    logic [63:0] sum;
    logic [63:0] term;
    int          sh;
    sum = 64'd0;
    if (i == 0) begin
      sum = 64'd45 << Z_FRAC;
    end else begin
      for (int k = 0; k < ATAN_TERMS; k++) begin
        sh = i * (2 * k + 1);
        if (sh < ATAN_SH_LIMIT) begin
          term = div_odd(DEG_PER_RAD >> sh, k);
          if (k % 2 == 1) sum = sum - term;
          else            sum = sum + term;
        end
      end
    end
    return sum[ZW-1:0];
  endfunction

endpackage

[rtl/heading_angle_from_points.sv]
// Heading of the displacement between two points, clockwise from +y, in degrees.
// Depends on hafp_pkg for widths, the pipeline record and the angle table.
// Throughput: one request per cycle while the output skid stage is empty;
// set by the 40 pipelined CORDIC stages, one micro-rotation each, plus
// input, normalise and rounding stages.
// Reset (rst, synchronous) clears all valid bits and the output skid stage.
module heading_angle_from_points #(
  parameter int COORD_WIDTH     = hafp_pkg::COORD_WIDTH_DEF,
  parameter int ANGLE_FRAC_BITS = hafp_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [31:0]                  start_x,
  input  logic [31:0]                  start_y,
  input  logic [31:0]                  end_x,
  input  logic [31:0]                  end_y,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [hafp_pkg::HEAD_W-1:0]  heading_deg
);
  import hafp_pkg::*;

  localparam int DW   = COORD_WIDTH + 1;
  localparam int DROP = Z_FRAC - ANGLE_FRAC_BITS;
  localparam logic [ZW-1:0] Z_HALF = ZW'(64'd1 << (DROP - 1));
  localparam logic [ZW-1:0] Z_180  = ZW'(64'd180 << Z_FRAC);
  localparam logic [ZW-1:0] Z_360  = ZW'(64'd360 << Z_FRAC);
  localparam logic [ZW-1:0] FULL   = ZW'(64'd360 << ANGLE_FRAC_BITS);
  localparam logic [ZW-1:0] R_ZERO = ZW'(64'd90 << ANGLE_FRAC_BITS);

  logic en;

  logic          s1_valid;
  logic [DW-1:0] s1_dx, s1_dy;
  logic          s2_valid, s2_neg, s2_zero;
  logic [DW-1:0] s2_cx, s2_cy;
  logic          s3_valid, s3_neg, s3_zero;
  logic [DW-1:0] s3_ax, s3_cy, s3_mx;
  logic          s4_valid, s4_neg, s4_zero;
  logic [DW-1:0] s4_ax, s4_cy;
  logic [SH_W-1:0] s4_sh;

  cord_t cs [CORDIC_ITERS+1];
  logic  cv [CORDIC_ITERS+1];

  logic          r1_valid, r1_zero;
  logic [ZW-1:0] r1_z;
  logic          r2_valid, r2_zero;
  logic [ZW-1:0] r2_r;
  logic          pv;
  logic [HEAD_W-1:0] p_head;
  logic          skid_valid;
  logic [HEAD_W-1:0] skid;

  logic [DW-1:0]   cy_abs, mx_next;
  logic [SH_W-1:0] sh_next;
  logic [ZW-1:0]   z_fix, r_sum, r_wrap;
  logic            leave;

  assign en       = !skid_valid;
  assign in_ready = en;
  assign leave    = pv && en;

  always_comb begin
    cy_abs  = s2_cy[DW-1] ? -s2_cy : s2_cy;
    mx_next = (s2_cx > cy_abs) ? s2_cx : cy_abs;
    sh_next = '0;
    for (int b = 0; b < DW; b++) begin
      if (s3_mx[b]) sh_next = SH_W'(NORM_TOP - b);
    end
    z_fix  = r1_z;
    z_fix  = cs[CORDIC_ITERS].z[ZW-1] ? cs[CORDIC_ITERS].z + Z_360 : cs[CORDIC_ITERS].z;
    r_sum  = (r1_z + Z_HALF) >> DROP;
    r_wrap = r2_zero ? R_ZERO : ((r2_r >= FULL) ? r2_r - FULL : r2_r);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      cv[0]    <= 1'b0;
      r1_valid <= 1'b0;
      r2_valid <= 1'b0;
      pv       <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      cv[0]    <= s4_valid;
      r1_valid <= cv[CORDIC_ITERS];
      r2_valid <= r1_valid;
      pv       <= r2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dx <= {end_x[COORD_WIDTH-1], end_x[COORD_WIDTH-1:0]}
             - {start_x[COORD_WIDTH-1], start_x[COORD_WIDTH-1:0]};
      s1_dy <= {end_y[COORD_WIDTH-1], end_y[COORD_WIDTH-1:0]}
             - {start_y[COORD_WIDTH-1], start_y[COORD_WIDTH-1:0]};

      // turn by 180 degrees when dy is negative
      s2_neg  <= s1_dy[DW-1];
      s2_zero <= (s1_dx == '0) && (s1_dy == '0);
      s2_cx   <= s1_dy[DW-1] ? -s1_dy : s1_dy;
      s2_cy   <= s1_dy[DW-1] ? -s1_dx : s1_dx;

      s3_neg  <= s2_neg;
      s3_zero <= s2_zero;
      s3_ax   <= s2_cx;
      s3_cy   <= s2_cy;
      s3_mx   <= mx_next;

      s4_neg  <= s3_neg;
      s4_zero <= s3_zero;
      s4_ax   <= s3_ax;
      s4_cy   <= s3_cy;
      s4_sh   <= sh_next;

      cs[0].x    <= XW'(s4_ax) << s4_sh;
      cs[0].y    <= {{(XW-DW){s4_cy[DW-1]}}, s4_cy} << s4_sh;
      cs[0].z    <= s4_neg ? Z_180 : '0;
      cs[0].zero <= s4_zero;

      r1_z    <= z_fix;
      r1_zero <= cs[CORDIC_ITERS].zero;
      r2_r    <= r_sum;
      r2_zero <= r1_zero;
      p_head  <= r_wrap[HEAD_W-1:0];
    end
  end

  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_rot
    localparam logic [ZW-1:0] STEP = atan_step(i);
    cord_t nxt;
    logic signed [XW-1:0] xs, ys;

    always_comb begin
      xs = cs[i].x >>> i;
      ys = cs[i].y >>> i;
      nxt.zero = cs[i].zero;
      if (!cs[i].y[XW-1]) begin
        nxt.x = cs[i].x + ys;
        nxt.y = cs[i].y - xs;
        nxt.z = cs[i].z + STEP;
      end else begin
        nxt.x = cs[i].x - ys;
        nxt.y = cs[i].y + xs;
        nxt.z = cs[i].z - STEP;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        cv[i+1] <= 1'b0;
      end else if (en) begin
        cv[i+1] <= cv[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cs[i+1] <= nxt;
      end
    end
  end

  // output register with skid stage: hold the request that leaves the pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= leave;
      end
    end else if (leave) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      heading_deg <= skid_valid ? skid : p_head;
    end else if (leave) begin
      skid <= p_head;
    end
  end

endmodule

[rtl/hafp_check.sv]
// Port-level checks for heading_angle_from_points, attached by bind.
// Depends on hafp_pkg for the output width.
module hafp_check #(
  parameter int ANGLE_FRAC_BITS = hafp_pkg::ANGLE_FRAC_BITS_DEF
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [hafp_pkg::HEAD_W-1:0] heading_deg
);
  import hafp_pkg::*;

  localparam logic [63:0] FULL = 64'd360 << ANGLE_FRAC_BITS;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(heading_deg))
    else $error("stalled result changed or dropped");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (ANGLE_FRAC_BITS > 16) || (64'(heading_deg) < FULL))
    else $error("heading outside a full turn");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !$past(out_ready && !out_valid))
    else $error("input stalled with no result waiting");

endmodule

bind heading_angle_from_points hafp_check #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_check (.*);
